// File: rtl/centd_pkg.sv
// Package for the centroid defuzzifier: widths, limits, register indexes
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package centd_pkg;

  localparam int X_W        = 16;
  localparam int Y_W        = 16;
  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int MOM_W  = 64;
  localparam int AREA_W = 40;
  localparam int DEN_W  = 42;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int DIV_W  = 64;
  localparam int QUO_W  = 18;
  localparam int ITER_W = $clog2(QUO_W);

  localparam logic [Y_W-1:0] Y_ONE = 16'd32768;

  localparam logic [QUO_W-1:0]      SAT_POS_MAG = 18'd32767;
  localparam logic [QUO_W-1:0]      SAT_NEG_MAG = 18'd32768;
  localparam logic signed [X_W-1:0] CRISP_MAX   = 16'sh7FFF;
  localparam logic signed [X_W-1:0] CRISP_MIN   = 16'sh8000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_UNIVERSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIVERSE_FROM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIVERSE_TO   = 2'd2;

  localparam logic signed [X_W-1:0] UNIVERSE_FROM_RST = 16'sh8000;
  localparam logic signed [X_W-1:0] UNIVERSE_TO_RST   = 16'sh7FFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SQ,
    ST_MUL_W,
    ST_MUL_YS,
    ST_MUL_X3,
    ST_ACC_M,
    ST_FIN,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_LOAD
  } state_t;

endpackage

// File: rtl/centroid_defuzzifier.sv
// Centroid defuzzifier for a piecewise-linear membership function.
// A point with a segment holds s_tready low while the shared 36x18 multiplier runs
// ST_MUL_SQ to ST_ACC_M (4 products, 1 accumulate); other points leave it high.
// After the last point: ST_FIN, any tail segment, ST_CHECK, then, unless <= 1 point
// or zero area, 18 divider steps and ST_SIGN; ST_LOAD waits for a free output.
// Reset (rst, synchronous) clears sums, count, output valid; registers to defaults.
`timescale 1ns / 1ps

module centroid_defuzzifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,   // x_value [15:0], y_value [31:16]
  input  logic                             s_tlast,   // last_point
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,   // crisp_value [15:0]
  output logic                             m_tuser,   // result_valid
  input  logic                             cfg_we,
  input  logic [centd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [centd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import centd_pkg::*;

  state_t state, state_next;

  logic                     use_universe;
  logic signed [X_W-1:0]    universe_from;
  logic signed [X_W-1:0]    universe_to;

  logic signed [MOM_W-1:0]  moment_sum;
  logic signed [AREA_W-1:0] area_sum;
  logic signed [X_W-1:0]    prev_x;
  logic [Y_W-1:0]           prev_y;
  logic signed [X_W-1:0]    first_x;
  logic [CNT_W-1:0]         point_count;
  logic                     in_last;
  logic                     tail_phase;

  logic signed [X_W:0]      seg_dx;
  logic [Y_W:0]             seg_ys;
  logic [Y_W+1:0]           seg_w;
  logic signed [X_W+1:0]    seg_x3;

  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic [DIV_W-1:0]         div_rem;
  logic [DIV_W-1:0]         div_ds;
  logic [QUO_W-1:0]         quo;
  logic [ITER_W-1:0]        iter;
  logic                     quo_neg;
  logic                     div_ge;

  logic signed [X_W-1:0]    res_crisp;
  logic                     res_valid;

  logic                     accept;
  logic signed [X_W-1:0]    in_x;
  logic [Y_W-1:0]           in_y_raw;
  logic [Y_W-1:0]           in_y;
  logic                     first_pt;
  logic                     room;
  logic                     head_seg;
  logic                     acc_seg;
  logic                     tail_seg;

  logic signed [X_W-1:0]    sx1;
  logic signed [X_W-1:0]    sx2;
  logic [Y_W-1:0]           sy1;
  logic [Y_W-1:0]           sy2;
  logic signed [X_W:0]      dx_c;
  logic [Y_W:0]             ys_c;
  logic [Y_W+1:0]           w_c;
  logic signed [X_W+1:0]    x3_c;

  logic signed [X_W-1:0]    xmin;
  logic signed [X_W-1:0]    xmax;
  logic signed [X_W:0]      msum;
  logic signed [X_W:0]      mid17;
  logic signed [X_W-1:0]    mid_c;
  logic signed [DEN_W-1:0]  den3;
  logic [DEN_W-1:0]         den_abs;
  logic [DIV_W-1:0]         mom_abs;
  logic signed [X_W-1:0]    sat_c;

  assign accept   = s_tvalid && s_tready;
  assign in_x     = signed'(s_tdata[X_W-1:0]);
  assign in_y_raw = s_tdata[X_W+Y_W-1:X_W];
  assign in_y     = (in_y_raw > Y_ONE) ? Y_ONE : in_y_raw;

  assign first_pt = (point_count == '0);
  assign room     = (point_count < CNT_W'(MAX_POINTS));
  assign head_seg = use_universe && (in_y != '0) && (in_x != universe_from);
  assign acc_seg  = first_pt ? head_seg : room;
  assign tail_seg = (point_count > CNT_W'(1)) && use_universe && (prev_y != '0) &&
                    (prev_x < universe_to);

  // segment end points: tail, head or ordinary
  always_comb begin
    if (state == ST_FIN) begin
      sx1 = prev_x;
      sy1 = prev_y;
      sx2 = universe_to;
      sy2 = prev_y;
    end else if (first_pt) begin
      sx1 = universe_from;
      sy1 = in_y;
      sx2 = in_x;
      sy2 = in_y;
    end else begin
      sx1 = prev_x;
      sy1 = prev_y;
      sx2 = in_x;
      sy2 = in_y;
    end
  end

  assign dx_c = {sx2[X_W-1], sx2} - {sx1[X_W-1], sx1};
  assign ys_c = {1'b0, sy1} + {1'b0, sy2};
  assign w_c  = {1'b0, sy2, 1'b0} + {2'b00, sy1};
  assign x3_c = {sx1[X_W-1], sx1, 1'b0} + {sx1[X_W-1], sx1[X_W-1], sx1};

  // bounds midpoint, rounded toward zero
  assign xmin  = use_universe ? universe_from : first_x;
  assign xmax  = use_universe ? universe_to : prev_x;
  assign msum  = {xmin[X_W-1], xmin} + {xmax[X_W-1], xmax};
  assign mid17 = msum + (X_W+1)'(msum[X_W]);
  assign mid_c = mid17[X_W:1];

  assign den3    = {{(DEN_W-AREA_W){area_sum[AREA_W-1]}}, area_sum} +
                   {{(DEN_W-AREA_W-1){area_sum[AREA_W-1]}}, area_sum, 1'b0};
  assign den_abs = area_sum[AREA_W-1] ? DEN_W'(-den3) : DEN_W'(den3);
  assign mom_abs = moment_sum[MOM_W-1] ? DIV_W'(-moment_sum) : DIV_W'(moment_sum);

  assign div_ge = (div_rem >= div_ds);

  always_comb begin
    if (quo_neg) begin
      sat_c = (quo > SAT_NEG_MAG) ? CRISP_MIN : signed'(X_W'(-quo[X_W-1:0]));
    end else begin
      sat_c = (quo > SAT_POS_MAG) ? CRISP_MAX : signed'(quo[X_W-1:0]);
    end
  end

  assign prod_c = mul_a * mul_b;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = acc_seg ? ST_MUL_SQ : (s_tlast ? ST_FIN : ST_IDLE);
        end
      end
      ST_MUL_SQ: state_next = ST_MUL_W;
      ST_MUL_W:  state_next = ST_MUL_YS;
      ST_MUL_YS: state_next = ST_MUL_X3;
      ST_MUL_X3: state_next = ST_ACC_M;
      ST_ACC_M: begin
        state_next = !in_last ? ST_IDLE : (tail_phase ? ST_CHECK : ST_FIN);
      end
      ST_FIN: state_next = tail_seg ? ST_MUL_SQ : ST_CHECK;
      ST_CHECK: begin
        state_next = ((point_count <= CNT_W'(1)) || (area_sum == '0)) ? ST_LOAD : ST_DIV;
      end
      ST_DIV:  state_next = (iter == '0) ? ST_SIGN : ST_DIV;
      ST_SIGN: state_next = ST_LOAD;
      ST_LOAD: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operands
  always_comb begin
    s_tready = (state == ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_MUL_SQ: begin
        mul_a = {{(MUL_A_W-X_W-1){seg_dx[X_W]}}, seg_dx};
        mul_b = {{(MUL_B_W-X_W-1){seg_dx[X_W]}}, seg_dx};
      end
      ST_MUL_W: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = signed'(seg_w);
      end
      ST_MUL_YS: begin
        mul_a = {{(MUL_A_W-X_W-1){seg_dx[X_W]}}, seg_dx};
        mul_b = signed'({1'b0, seg_ys});
      end
      ST_MUL_X3: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = seg_x3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      use_universe  <= 1'b0;
      universe_from <= UNIVERSE_FROM_RST;
      universe_to   <= UNIVERSE_TO_RST;
      moment_sum    <= '0;
      area_sum      <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      first_x       <= '0;
      point_count   <= '0;
      in_last       <= 1'b0;
      tail_phase    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_USE_UNIVERSE:  use_universe  <= cfg_data[0];
          CFG_UNIVERSE_FROM: universe_from <= signed'(cfg_data[X_W-1:0]);
          CFG_UNIVERSE_TO:   universe_to   <= signed'(cfg_data[X_W-1:0]);
          default: ;
        endcase
      end

      // a load in the same cycle refills the output register instead
      if (m_tvalid && m_tready && (state != ST_LOAD)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            in_last    <= s_tlast;
            tail_phase <= 1'b0;
            if (acc_seg) begin
              seg_dx <= dx_c;
              seg_ys <= ys_c;
              seg_w  <= w_c;
              seg_x3 <= x3_c;
            end
            if (first_pt) begin
              moment_sum  <= '0;
              area_sum    <= '0;
              first_x     <= in_x;
              prev_x      <= in_x;
              prev_y      <= in_y;
              point_count <= CNT_W'(1);
            end else if (room) begin
              prev_x      <= in_x;
              prev_y      <= in_y;
              point_count <= point_count + CNT_W'(1);
            end
          end
        end
        ST_MUL_SQ, ST_MUL_W: prod <= prod_c;
        ST_MUL_YS: begin
          prod       <= prod_c;
          moment_sum <= moment_sum + {{(MOM_W-PROD_W){prod[PROD_W-1]}}, prod};
        end
        ST_MUL_X3: begin
          prod     <= prod_c;
          area_sum <= area_sum + prod[AREA_W-1:0];
        end
        ST_ACC_M: begin
          moment_sum <= moment_sum + {{(MOM_W-PROD_W){prod[PROD_W-1]}}, prod};
        end
        ST_FIN: begin
          if (tail_seg) begin
            seg_dx     <= dx_c;
            seg_ys     <= ys_c;
            seg_w      <= w_c;
            seg_x3     <= x3_c;
            tail_phase <= 1'b1;
          end
        end
        ST_CHECK: begin
          res_crisp <= mid_c;
          res_valid <= (point_count <= CNT_W'(1)) ? (prev_y != '0) : 1'b0;
          div_rem   <= mom_abs;
          div_ds    <= {{(DIV_W-DEN_W-QUO_W+1){1'b0}}, den_abs, {(QUO_W-1){1'b0}}};
          quo       <= '0;
          quo_neg   <= moment_sum[MOM_W-1] ^ area_sum[AREA_W-1];
          iter      <= ITER_W'(QUO_W - 1);
        end
        ST_DIV: begin
          if (div_ge) begin
            div_rem <= div_rem - div_ds;
          end
          quo    <= {quo[QUO_W-2:0], div_ge};
          div_ds <= div_ds >> 1;
          iter   <= iter - ITER_W'(1);
        end
        ST_SIGN: begin
          res_crisp <= sat_c;
          res_valid <= 1'b1;
        end
        ST_LOAD: begin
          if (!m_tvalid || m_tready) begin
            m_tdata     <= res_crisp;
            m_tuser     <= res_valid;
            m_tvalid    <= 1'b1;
            point_count <= '0;
            moment_sum  <= '0;
            area_sum    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
